### src/srcut_pkg.sv
package srcut_pkg;

  // field widths
  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned CoefWidth    = 16;
  localparam int unsigned CoefFracBits = 14;
  localparam int unsigned RowWidth     = 3 * CoefWidth;
  localparam int unsigned ProdWidth    = CoefWidth + CoordWidth;
  localparam int unsigned SumWidth     = ProdWidth + 2;
  localparam int unsigned CutWidth     = 2 * CoordWidth - 1;
  localparam int unsigned RemWidth     = CutWidth;
  localparam int unsigned ResWidth     = 2 * CoordWidth;
  localparam int unsigned RootSteps    = CoordWidth;
  localparam int unsigned ZWidth       = CoordWidth - 1;

  // register port
  localparam int unsigned AddrWidth = 6;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned IdxLsb    = 3;

  typedef logic [AddrWidth-1-IdxLsb:0] reg_idx_t;

  localparam reg_idx_t RegMode    = reg_idx_t'(0);
  localparam reg_idx_t RegRowX    = reg_idx_t'(1);
  localparam reg_idx_t RegRowY    = reg_idx_t'(2);
  localparam reg_idx_t RegOffsetX = reg_idx_t'(3);
  localparam reg_idx_t RegOffsetY = reg_idx_t'(4);
  localparam reg_idx_t RegCutoff  = reg_idx_t'(5);

  // reset values: identity on the first two rows
  localparam logic [RowWidth-1:0] RowXReset = RowWidth'(64'd16384);
  localparam logic [RowWidth-1:0] RowYReset = RowWidth'(64'd1073741824);

  typedef struct packed {
    logic                         mode;
    logic [RowWidth-1:0]          row_x;
    logic [RowWidth-1:0]          row_y;
    logic signed [CoordWidth-1:0] off_x;
    logic signed [CoordWidth-1:0] off_y;
    logic [CutWidth-1:0]          cutoff_sq;
  } cfg_t;

  // word handed along the root chain
  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    logic [RemWidth-1:0]          rem;
    logic [ResWidth-1:0]          res;
  } root_word_t;

endpackage

### src/srcut_regs.sv
module srcut_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srcut_pkg::AddrWidth-1:0] paddr,
  input  logic [srcut_pkg::DataWidth-1:0] pwdata,
  output logic [srcut_pkg::DataWidth-1:0] prdata,
  output logic                            pready,
  output srcut_pkg::cfg_t                 cfg_o
);
  import srcut_pkg::*;

  cfg_t     cfg_q;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[AddrWidth-1:IdxLsb];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= 1'b0;
      cfg_q.row_x     <= RowXReset;
      cfg_q.row_y     <= RowYReset;
      cfg_q.off_x     <= '0;
      cfg_q.off_y     <= '0;
      cfg_q.cutoff_sq <= '0;
    end else if (wr_en) begin
      case (idx)
        RegMode:    cfg_q.mode      <= pwdata[0];
        RegRowX:    cfg_q.row_x     <= pwdata[RowWidth-1:0];
        RegRowY:    cfg_q.row_y     <= pwdata[RowWidth-1:0];
        RegOffsetX: cfg_q.off_x     <= pwdata[CoordWidth-1:0];
        RegOffsetY: cfg_q.off_y     <= pwdata[CoordWidth-1:0];
        RegCutoff:  cfg_q.cutoff_sq <= pwdata[CutWidth-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      RegMode:    prdata = DataWidth'(cfg_q.mode);
      RegRowX:    prdata = DataWidth'(cfg_q.row_x);
      RegRowY:    prdata = DataWidth'(cfg_q.row_y);
      RegOffsetX: prdata = DataWidth'(unsigned'(cfg_q.off_x));
      RegOffsetY: prdata = DataWidth'(unsigned'(cfg_q.off_y));
      RegCutoff:  prdata = DataWidth'(cfg_q.cutoff_sq);
      default:    prdata = '0;
    endcase
  end

endmodule

### src/srcut_front.sv
module srcut_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  srcut_pkg::cfg_t                         cfg_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [srcut_pkg::CoordWidth-1:0] in_x_i,
  input  logic signed [srcut_pkg::CoordWidth-1:0] in_y_i,
  input  logic signed [srcut_pkg::CoordWidth-1:0] in_z_i,
  output logic                                    word_valid_o,
  output srcut_pkg::root_word_t                   word_o,
  input  logic                                    word_stall_i
);
  import srcut_pkg::*;

  localparam logic signed [SumWidth-1:0] RoundHalf = SumWidth'(1) << (CoefFracBits - 1);
  localparam logic signed [SumWidth-1:0] SumMax    = (SumWidth'(1) << (CoordWidth - 1)) - 1;
  localparam logic signed [SumWidth-1:0] SumMin    = -SumMax - 1;

  function automatic logic signed [CoordWidth-1:0] sat_coord(
    input logic signed [SumWidth-1:0] v
  );
    logic signed [CoordWidth-1:0] r;
    if (v > SumMax) begin
      r = SumMax[CoordWidth-1:0];
    end else if (v < SumMin) begin
      r = SumMin[CoordWidth-1:0];
    end else begin
      r = v[CoordWidth-1:0];
    end
    return r;
  endfunction

  // stage stall chain, a stage holds only when full and blocked
  logic st1, st2, st3, st4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign st4        = v4_q && word_stall_i;
  assign st3        = v3_q && st4;
  assign st2        = v2_q && st3;
  assign st1        = v1_q && st2;
  assign in_stall_o = st1;

  // stage 1: row products or offset differences
  logic signed [CoordWidth-1:0] vec [3];
  logic signed [CoefWidth-1:0]  cx [3];
  logic signed [CoefWidth-1:0]  cy [3];
  logic signed [ProdWidth-1:0]  px_d [3];
  logic signed [ProdWidth-1:0]  py_d [3];
  logic signed [ProdWidth-1:0]  px_q [3];
  logic signed [ProdWidth-1:0]  py_q [3];
  logic signed [CoordWidth:0]   dx_d, dy_d, dx_q, dy_q;

  assign vec[0] = in_x_i;
  assign vec[1] = in_y_i;
  assign vec[2] = in_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cx[i]   = cfg_i.row_x[i*CoefWidth +: CoefWidth];
      cy[i]   = cfg_i.row_y[i*CoefWidth +: CoefWidth];
      px_d[i] = cx[i] * vec[i];
      py_d[i] = cy[i] * vec[i];
    end
  end

  assign dx_d = in_x_i - cfg_i.off_x;
  assign dy_d = in_y_i - cfg_i.off_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (!st1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!st1 && in_valid_i) begin
      px_q <= px_d;
      py_q <= py_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // stage 2: sum, round half up and saturate, or saturate the offset differences
  logic signed [SumWidth-1:0]   sum_x, sum_y, sh_x, sh_y;
  logic signed [CoordWidth-1:0] x2_d, y2_d, x2_q, y2_q;

  always_comb begin
    sum_x = px_q[0] + px_q[1] + px_q[2] + RoundHalf;
    sum_y = py_q[0] + py_q[1] + py_q[2] + RoundHalf;
    sh_x  = sum_x >>> CoefFracBits;
    sh_y  = sum_y >>> CoefFracBits;
    if (cfg_i.mode) begin
      x2_d = sat_coord(SumWidth'(dx_q));
      y2_d = sat_coord(SumWidth'(dy_q));
    end else begin
      x2_d = sat_coord(sh_x);
      y2_d = sat_coord(sh_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (!st2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!st2 && v1_q) begin
      x2_q <= x2_d;
      y2_q <= y2_d;
    end
  end

  // stage 3: squares of the magnitudes
  logic [CoordWidth-1:0]        ax, ay;
  logic [ResWidth-1:0]          sqx_d, sqy_d, sqx_q, sqy_q;
  logic signed [CoordWidth-1:0] x3_q, y3_q;

  assign ax    = x2_q[CoordWidth-1] ? CoordWidth'(-x2_q) : CoordWidth'(x2_q);
  assign ay    = y2_q[CoordWidth-1] ? CoordWidth'(-y2_q) : CoordWidth'(y2_q);
  assign sqx_d = ax * ax;
  assign sqy_d = ay * ay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (!st3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!st3 && v2_q) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      x3_q  <= x2_q;
      y3_q  <= y2_q;
    end
  end

  // stage 4: remaining cutoff, evanescent words dropped here
  logic [ResWidth-1:0] mag_sq;
  logic                keep;
  root_word_t          w4_q;

  assign mag_sq = sqx_q + sqy_q;
  assign keep   = mag_sq <= ResWidth'(cfg_i.cutoff_sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (!st4) begin
      v4_q <= v3_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!st4 && v3_q && keep) begin
      w4_q.x   <= x3_q;
      w4_q.y   <= y3_q;
      w4_q.rem <= cfg_i.cutoff_sq - mag_sq[RemWidth-1:0];
      w4_q.res <= '0;
    end
  end

  assign word_valid_o = v4_q;
  assign word_o       = w4_q;

endmodule

### src/srcut_root_cell.sv
module srcut_root_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  srcut_pkg::root_word_t in_word_i,
  output logic                  out_valid_o,
  output srcut_pkg::root_word_t out_word_o,
  input  logic                  out_stall_i
);
  import srcut_pkg::*;

  localparam logic [ResWidth-1:0] RootBit = ResWidth'(1) << (2 * Step);

  logic                valid_q;
  root_word_t          word_q, word_d;
  logic [ResWidth-1:0] trial;
  logic                take;

  assign in_stall_o = valid_q && out_stall_i;

  // one root bit: compare against res + 4^step
  always_comb begin
    trial       = in_word_i.res + RootBit;
    take        = ResWidth'(in_word_i.rem) >= trial;
    word_d      = in_word_i;
    if (take) begin
      word_d.rem = in_word_i.rem - trial[RemWidth-1:0];
      word_d.res = (in_word_i.res >> 1) + RootBit;
    end else begin
      word_d.res = in_word_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

### src/spectrum_remap_with_cutoff_unit.sv
// stages: 4 front stages, then 32 root cells
// throughput: one word per cycle while out_stall_i is low; each stage and root cell holds one
//   word; a stage holds only when full and the next one holds, so gaps are squeezed out
// words whose cutoff goes negative are dropped in the fourth stage and give no result
// reset: rst_ni is asynchronous, active low; it empties the pipeline and loads the
//   register defaults (matrix mode, identity rows, zero offsets, zero cutoff)
module spectrum_remap_with_cutoff_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [srcut_pkg::CoordWidth-1:0] in_x_i,
  input  logic signed [srcut_pkg::CoordWidth-1:0] in_y_i,
  input  logic signed [srcut_pkg::CoordWidth-1:0] in_z_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [srcut_pkg::CoordWidth-1:0] out_x_o,
  output logic signed [srcut_pkg::CoordWidth-1:0] out_y_o,
  output logic [srcut_pkg::ZWidth-1:0]            out_z_o,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [srcut_pkg::AddrWidth-1:0]         paddr,
  input  logic [srcut_pkg::DataWidth-1:0]         pwdata,
  output logic [srcut_pkg::DataWidth-1:0]         prdata,
  output logic                                    pready
);
  import srcut_pkg::*;

  cfg_t       cfg;
  logic       chain_valid [RootSteps+1];
  logic       chain_stall [RootSteps+1];
  root_word_t chain_word  [RootSteps+1];
  root_word_t last_word;

  // configuration registers
  srcut_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // transform, square and cutoff compare
  srcut_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_x_i       (in_x_i),
    .in_y_i       (in_y_i),
    .in_z_i       (in_z_i),
    .word_valid_o (chain_valid[0]),
    .word_o       (chain_word[0]),
    .word_stall_i (chain_stall[0])
  );

  // root chain, most significant root bit first
  for (genvar k = 0; k < RootSteps; k++) begin : g_cell
    srcut_root_cell #(
      .Step (RootSteps - 1 - k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_stall_o  (chain_stall[k]),
      .in_word_i   (chain_word[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_word_o  (chain_word[k+1]),
      .out_stall_i (chain_stall[k+1])
    );
  end

  assign chain_stall[RootSteps] = out_stall_i;
  assign last_word              = chain_word[RootSteps];

  // result word, root clipped to the output range
  assign out_valid_o = chain_valid[RootSteps];
  assign out_x_o     = last_word.x;
  assign out_y_o     = last_word.y;
  assign out_z_o     = last_word.res[RootSteps-1] ? {ZWidth{1'b1}} : last_word.res[ZWidth-1:0];

endmodule

### src/srcut_checker.sv
module srcut_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_stall_o,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic signed [srcut_pkg::CoordWidth-1:0] out_x_o,
  input logic signed [srcut_pkg::CoordWidth-1:0] out_y_o,
  input logic [srcut_pkg::ZWidth-1:0]            out_z_o,
  input logic                                    psel,
  input logic                                    penable,
  input logic                                    pwrite,
  input logic [srcut_pkg::AddrWidth-1:0]         paddr,
  input logic [srcut_pkg::DataWidth-1:0]         pwdata,
  input logic [srcut_pkg::DataWidth-1:0]         prdata,
  input logic                                    pready
);
  import srcut_pkg::*;

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result word shown right after reset");

  // input stall only ever comes from a blocked result word
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output is free");

  // a blocked result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o)
      && $stable(out_z_o))
    else $error("blocked result word changed");

  // x offset reads back what was written
  a_offset_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[AddrWidth-1:IdxLsb] == RegOffsetX
      ##1 psel && !pwrite && paddr[AddrWidth-1:IdxLsb] == RegOffsetX)
    |-> prdata[CoordWidth-1:0] == $past(pwdata[CoordWidth-1:0]))
    else $error("x offset read back wrong");

endmodule

bind spectrum_remap_with_cutoff_unit srcut_checker u_checker (.*);
